/* src/bscu_pkg.sv */
`timescale 1ns / 1ps

package bscu_pkg;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_OSS      = 3'd3,
    REG_TEMP_MIN = 3'd4,
    REG_TEMP_MAX = 3'd5
  } reg_idx_t;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam int DIV1_STEPS = 27;
  localparam int DIV2_STEPS = 32;

  localparam logic [1:0]         OSS_RST      = 2'd3;
  localparam logic signed [15:0] TEMP_MIN_RST = -16'sd400;
  localparam logic signed [15:0] TEMP_MAX_RST = 16'sd850;

  localparam int C_B6_OFFSET = 4000;
  localparam int C_X3_BIAS   = 32768;
  localparam int C_P_SCALE   = 50000;
  localparam int C_K1        = 3038;
  localparam int C_K2        = -7357;
  localparam int C_K3        = 3791;

  localparam logic [19:0] PRESS_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [18:0] x1;
    logic [18:0] up;
    logic        neg;
    logic        dz;
    logic [19:0] d;
    logic [46:0] acc;
  } d1_t;

  typedef struct packed {
    logic [15:0] t;
    logic        fail;
    logic        hi;
    logic        bz;
    logic [16:0] d;
    logic [48:0] acc;
  } d2_t;

  // One restoring step: remainder in the upper bits, dividend shifting out
  // as quotient bits shift in at the bottom.
  function automatic logic [46:0] div1_step(input logic [46:0] acc, input logic [19:0] d);
    logic [47:0] sh;
    logic [20:0] rem;
    logic        qb;
    sh  = {acc, 1'b0};
    rem = sh[47:27];
    qb  = (rem >= {1'b0, d});
    if (qb) begin
      rem = rem - {1'b0, d};
    end
    return {rem[19:0], sh[26:1], qb};
  endfunction

  function automatic logic [48:0] div2_step(input logic [48:0] acc, input logic [16:0] d);
    logic [49:0] sh;
    logic [17:0] rem;
    logic        qb;
    sh  = {acc, 1'b0};
    rem = sh[49:32];
    qb  = (rem >= {1'b0, d});
    if (qb) begin
      rem = rem - {1'b0, d};
    end
    return {rem[16:0], sh[31:1], qb};
  endfunction

endpackage

/* src/baro_sensor_compensation_unit.sv */
`timescale 1ns / 1ps
// Throughput: one item per cycle while the skid stage is empty;
// the pipeline has 76 stages, most of them in the two bit-per-stage
// dividers (27 and 32 stages).
// A one-entry skid stage behind the output register stops the pipeline only when full.
// Reset is synchronous: it empties the pipeline and loads register defaults.
module baro_sensor_compensation_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bscu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bscu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       raw_temperature,
  input  logic [23:0]                       raw_pressure,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                temperature,
  output logic [19:0]                       pressure,
  output logic                              range_fail
);
  import bscu_pkg::*;

  localparam int NUM_ST = DIV1_STEPS + DIV2_STEPS + 17;

  logic [63:0]        coef_a;
  logic [63:0]        coef_b;
  logic [31:0]        coef_c;
  logic [1:0]         oss;
  logic signed [15:0] temp_min;
  logic signed [15:0] temp_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a   <= '0;
      coef_b   <= '0;
      coef_c   <= '0;
      oss      <= OSS_RST;
      temp_min <= TEMP_MIN_RST;
      temp_max <= TEMP_MAX_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_A:   coef_a   <= cfg_data;
        REG_COEF_B:   coef_b   <= cfg_data;
        REG_COEF_C:   coef_c   <= cfg_data[31:0];
        REG_OSS:      oss      <= cfg_data[1:0];
        REG_TEMP_MIN: temp_min <= cfg_data[15:0];
        REG_TEMP_MAX: temp_max <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = coef_a[15:0];
  assign ac2 = coef_a[31:16];
  assign ac3 = coef_a[47:32];
  assign ac4 = coef_a[63:48];
  assign ac5 = coef_b[15:0];
  assign ac6 = coef_b[31:16];
  assign b1  = coef_b[47:32];
  assign b2  = coef_b[63:48];
  assign mc  = coef_c[15:0];
  assign md  = coef_c[31:16];

  // Pipeline control and output skid stage.
  logic              go;
  logic [NUM_ST-1:0] vld;
  logic              skid_v;
  logic signed [15:0] f4_temp, skid_temp;
  logic [19:0]        f4_press, skid_press;
  logic               f4_fail, skid_fail;

  assign go       = !skid_v;
  assign in_ready = go;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (go) begin
      vld <= {vld[NUM_ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        temperature <= skid_temp;
        pressure    <= skid_press;
        range_fail  <= skid_fail;
        skid_v      <= 1'b0;
      end
    end else if (vld[NUM_ST-1]) begin
      if (!out_valid || out_ready) begin
        temperature <= f4_temp;
        pressure    <= f4_press;
        range_fail  <= f4_fail;
        out_valid   <= 1'b1;
      end else begin
        skid_temp  <= f4_temp;
        skid_press <= f4_press;
        skid_fail  <= f4_fail;
        skid_v     <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Temperature front end, with the raw pressure aligned to the oversampling setting.
  logic signed [16:0] s1_diff;
  logic [18:0]        s1_up, s2_up;
  logic signed [33:0] s2_prod;

  always_ff @(posedge clk) begin
    if (go) begin
      s1_diff <= $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
      s1_up   <= 19'(raw_pressure >> (4'd8 - {2'b00, oss}));
      s2_prod <= s1_diff * $signed({1'b0, ac5});
      s2_up   <= s1_up;
    end
  end

  logic signed [18:0] s3_x1;
  logic signed [19:0] s3_den;
  logic signed [26:0] s3_num;
  logic [26:0]        s3_nmag;
  logic [19:0]        s3_dmag;

  always_comb begin
    s3_x1   = s2_prod[33:15];
    s3_den  = 20'(s3_x1) + 20'(md);
    s3_num  = {mc, 11'b0};
    s3_nmag = s3_num[26] ? 27'(-s3_num) : 27'(s3_num);
    s3_dmag = s3_den[19] ? 20'(-s3_den) : 20'(s3_den);
  end

  d1_t d1 [0:DIV1_STEPS];

  always_ff @(posedge clk) begin
    if (go) begin
      d1[0].x1  <= s3_x1;
      d1[0].up  <= s2_up;
      d1[0].neg <= s3_num[26] ^ s3_den[19];
      d1[0].dz  <= (s3_den == '0);
      d1[0].d   <= s3_dmag;
      d1[0].acc <= {20'b0, s3_nmag};
    end
  end

  for (genvar k = 1; k <= DIV1_STEPS; k++) begin : g_div1
    always_ff @(posedge clk) begin
      if (go) begin
        d1[k].x1  <= d1[k-1].x1;
        d1[k].up  <= d1[k-1].up;
        d1[k].neg <= d1[k-1].neg;
        d1[k].dz  <= d1[k-1].dz;
        d1[k].d   <= d1[k-1].d;
        d1[k].acc <= div1_step(d1[k-1].acc, d1[k-1].d);
      end
    end
  end

  // Temperature result and pressure coefficients.
  logic signed [27:0] e1_x2c;
  logic signed [28:0] e1_b5, e2_tsum;
  logic signed [24:0] e2_t;
  logic               e2_fail_c;

  always_comb begin
    if (d1[DIV1_STEPS].dz) begin
      e1_x2c = '0;
    end else if (d1[DIV1_STEPS].neg) begin
      e1_x2c = -$signed({1'b0, d1[DIV1_STEPS].acc[26:0]});
    end else begin
      e1_x2c = $signed({1'b0, d1[DIV1_STEPS].acc[26:0]});
    end
    e2_tsum   = e1_b5 + 29'sd8;
    e2_t      = e2_tsum[28:4];
    e2_fail_c = (e2_t < 25'(temp_min)) || (e2_t > 25'(temp_max));
  end

  logic [18:0]        e1_up, e2_up, e3_up, e4_up, e5_up, e6_up, e7_up;
  logic [15:0]        e2_t16, e3_t16, e4_t16, e5_t16, e6_t16, e7_t16, e8_t16, e9_t16;
  logic               e2_fail, e3_fail, e4_fail, e5_fail, e6_fail, e7_fail, e8_fail,
                      e9_fail;
  logic signed [29:0] e2_b6;
  logic signed [59:0] e3_sqf;
  logic signed [45:0] e3_m2, e3_m3;
  logic signed [47:0] e4_sq;
  logic signed [34:0] e4_x2a, e5_x2a;
  logic signed [32:0] e4_x1c, e5_x1c;
  logic signed [63:0] e5_p1, e5_p2;
  logic signed [53:0] e6_x3a;
  logic signed [46:0] e6_x3c;
  logic [31:0]        e7_b3, e7_m4, e8_dp, e9_b7;
  logic [16:0]        e8_b4, e9_b4;

  logic signed [48:0] e6_sum;
  logic [33:0]        e7_v, e7_w;
  logic [47:0]        e8_m;
  logic [15:0]        e9_scale;

  always_comb begin
    e6_sum   = 49'($signed(e5_p2[63:16])) + 49'(e5_x1c) + 49'sd2;
    e7_v     = {{16{ac1[15]}}, ac1, 2'b00} + e6_x3a[33:0];
    e7_w     = (e7_v << oss) + 34'd2;
    e8_m     = 48'(ac4) * 48'(e7_m4);
    e9_scale = 16'(C_P_SCALE >> oss);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      e1_b5   <= 29'($signed(d1[DIV1_STEPS].x1)) + 29'(e1_x2c);
      e1_up   <= d1[DIV1_STEPS].up;

      e2_t16  <= e2_t[15:0];
      e2_fail <= e2_fail_c;
      e2_b6   <= 30'(e1_b5) - 30'(C_B6_OFFSET);
      e2_up   <= e1_up;

      e3_sqf  <= e2_b6 * e2_b6;
      e3_m2   <= ac2 * e2_b6;
      e3_m3   <= ac3 * e2_b6;
      e3_t16  <= e2_t16;
      e3_fail <= e2_fail;
      e3_up   <= e2_up;

      e4_sq   <= e3_sqf[59:12];
      e4_x2a  <= e3_m2[45:11];
      e4_x1c  <= e3_m3[45:13];
      e4_t16  <= e3_t16;
      e4_fail <= e3_fail;
      e4_up   <= e3_up;

      e5_p1   <= b2 * e4_sq;
      e5_p2   <= b1 * e4_sq;
      e5_x2a  <= e4_x2a;
      e5_x1c  <= e4_x1c;
      e5_t16  <= e4_t16;
      e5_fail <= e4_fail;
      e5_up   <= e4_up;

      e6_x3a  <= 54'($signed(e5_p1[63:11])) + 54'(e5_x2a);
      e6_x3c  <= e6_sum[48:2];
      e6_t16  <= e5_t16;
      e6_fail <= e5_fail;
      e6_up   <= e5_up;

      e7_b3   <= e7_w[33:2];
      e7_m4   <= e6_x3c[31:0] + 32'(C_X3_BIAS);
      e7_t16  <= e6_t16;
      e7_fail <= e6_fail;
      e7_up   <= e6_up;

      e8_dp   <= {13'b0, e7_up} - e7_b3;
      e8_b4   <= e8_m[31:15];
      e8_t16  <= e7_t16;
      e8_fail <= e7_fail;

      e9_b7   <= e8_dp * 32'(e9_scale);
      e9_b4   <= e8_b4;
      e9_t16  <= e8_t16;
      e9_fail <= e8_fail;
    end
  end

  // Pressure quotient.
  d2_t d2 [0:DIV2_STEPS];

  always_ff @(posedge clk) begin
    if (go) begin
      d2[0].t    <= e9_t16;
      d2[0].fail <= e9_fail;
      d2[0].hi   <= e9_b7[31];
      d2[0].bz   <= (e9_b4 == '0);
      d2[0].d    <= e9_b4;
      d2[0].acc  <= {17'b0, (e9_b7[31] ? e9_b7 : {e9_b7[30:0], 1'b0})};
    end
  end

  for (genvar k = 1; k <= DIV2_STEPS; k++) begin : g_div2
    always_ff @(posedge clk) begin
      if (go) begin
        d2[k].t    <= d2[k-1].t;
        d2[k].fail <= d2[k-1].fail;
        d2[k].hi   <= d2[k-1].hi;
        d2[k].bz   <= d2[k-1].bz;
        d2[k].d    <= d2[k-1].d;
        d2[k].acc  <= div2_step(d2[k-1].acc, d2[k-1].d);
      end
    end
  end

  // Pressure polynomial correction and saturation; a failed item is zeroed.
  logic [31:0]        f1_q;
  logic signed [31:0] f1_p, f2_p, f3_p;
  logic signed [23:0] f1_a;
  logic signed [47:0] f2_aa;
  logic signed [45:0] f2_m2, f3_m2;
  logic signed [60:0] f3_m3;
  logic [15:0]        f1_t16, f2_t16, f3_t16;
  logic               f1_fail, f2_fail, f3_fail, f1_bz, f2_bz, f3_bz;

  assign f1_q = d2[DIV2_STEPS].hi ? {d2[DIV2_STEPS].acc[30:0], 1'b0}
                                  : d2[DIV2_STEPS].acc[31:0];

  always_ff @(posedge clk) begin
    if (go) begin
      f1_p    <= f1_q;
      f1_a    <= f1_q[31:8];
      f1_t16  <= d2[DIV2_STEPS].t;
      f1_fail <= d2[DIV2_STEPS].fail;
      f1_bz   <= d2[DIV2_STEPS].bz;

      f2_aa   <= f1_a * f1_a;
      f2_m2   <= 15'(C_K2) * f1_p;
      f2_p    <= f1_p;
      f2_t16  <= f1_t16;
      f2_fail <= f1_fail;
      f2_bz   <= f1_bz;

      f3_m3   <= f2_aa * 13'(C_K1);
      f3_m2   <= f2_m2;
      f3_p    <= f2_p;
      f3_t16  <= f2_t16;
      f3_fail <= f2_fail;
      f3_bz   <= f2_bz;
    end
  end

  logic signed [45:0] f4_s;
  logic signed [46:0] f4_pf;
  logic signed [15:0] f4_temp_c;
  logic [19:0]        f4_press_c;

  always_comb begin
    f4_s  = 46'($signed(f3_m3[60:16])) + 46'($signed(f3_m2[45:16])) + 46'(C_K3);
    f4_pf = 47'(f3_p) + 47'($signed(f4_s[45:4]));
    if (f3_fail) begin
      f4_temp_c  = '0;
      f4_press_c = '0;
    end else begin
      f4_temp_c = f3_t16;
      if (f3_bz) begin
        f4_press_c = PRESS_MAX;
      end else if (f4_pf < 47'sd0) begin
        f4_press_c = '0;
      end else if (f4_pf > $signed({27'b0, PRESS_MAX})) begin
        f4_press_c = PRESS_MAX;
      end else begin
        f4_press_c = f4_pf[19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      f4_temp  <= f4_temp_c;
      f4_press <= f4_press_c;
      f4_fail  <= f3_fail;
    end
  end

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid stage holds an item while the output is empty");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_fail) |-> (temperature == 16'sd0 && pressure == 20'd0))
    else $error("failed item carries non-zero values");

  a_tail_delivered: assert property (@(posedge clk) disable iff (rst)
    (vld[NUM_ST-1] && !skid_v) |=> out_valid)
    else $error("item leaving the pipeline was lost");

endmodule
